FILE: hdl/stsd_pkg.sv
// Shared types, widths and constants for the sphere triangle subdivider.
package stsd_pkg;

  localparam int CW              = 16;
  localparam int DEPTH_W         = 2;
  localparam int MAX_DEPTH_DEF   = 3;
  localparam int COORD_FRAC_BITS = 14;
  localparam int SW              = CW + 1;
  localparam int SQW             = 2 * CW + 1;
  localparam int LW              = SQW + 2;
  localparam int QW              = 2 * COORD_FRAC_BITS + 1;
  localparam int RW              = COORD_FRAC_BITS + 1;
  localparam int RMW             = RW + 2;
  localparam int STEP_W          = $clog2(QW);
  localparam int QDEPTH          = 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } tri_t;

  typedef struct packed {
    tri_t              face;
    logic [DEPTH_W-1:0] depth;
  } item_t;

  typedef struct packed {
    logic start;
    vec_t p;
    vec_t q;
  } mid_req_t;

  typedef struct packed {
    logic done;
    vec_t m;
  } mid_rsp_t;

endpackage

FILE: hdl/sphere_triangle_subdivider_unit.sv
// Top level: front queue, subdivision sequencer and midpoint unit.
// A midpoint runs setup, 29 divide steps and 15 root steps; a zero-length edge sum skips both.
// Results leave one per cycle at most; a two-entry queue takes new triangles meanwhile.
// Synchronous active-high reset empties the queue and the result register and sets depth to 3.
module sphere_triangle_subdivider_unit #(
  parameter int MAX_DEPTH = stsd_pkg::MAX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         depth_we,
  input  logic [stsd_pkg::DEPTH_W-1:0] depth_wdata,
  input  logic                         push,
  output logic                         full,
  input  logic signed [stsd_pkg::CW-1:0] a_x,
  input  logic signed [stsd_pkg::CW-1:0] a_y,
  input  logic signed [stsd_pkg::CW-1:0] a_z,
  input  logic signed [stsd_pkg::CW-1:0] b_x,
  input  logic signed [stsd_pkg::CW-1:0] b_y,
  input  logic signed [stsd_pkg::CW-1:0] b_z,
  input  logic signed [stsd_pkg::CW-1:0] c_x,
  input  logic signed [stsd_pkg::CW-1:0] c_y,
  input  logic signed [stsd_pkg::CW-1:0] c_z,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [stsd_pkg::CW-1:0] out_a_x,
  output logic signed [stsd_pkg::CW-1:0] out_a_y,
  output logic signed [stsd_pkg::CW-1:0] out_a_z,
  output logic signed [stsd_pkg::CW-1:0] out_b_x,
  output logic signed [stsd_pkg::CW-1:0] out_b_y,
  output logic signed [stsd_pkg::CW-1:0] out_b_z,
  output logic signed [stsd_pkg::CW-1:0] out_c_x,
  output logic signed [stsd_pkg::CW-1:0] out_c_y,
  output logic signed [stsd_pkg::CW-1:0] out_c_z,
  output logic                         last
);
  import stsd_pkg::*;

  tri_t     in_tri;
  tri_t     out_tri;
  logic     q_valid;
  logic     q_pop;
  item_t    q_item;
  mid_req_t mid_req;
  mid_rsp_t mid_rsp;

  assign in_tri.a[0] = a_x;
  assign in_tri.a[1] = a_y;
  assign in_tri.a[2] = a_z;
  assign in_tri.b[0] = b_x;
  assign in_tri.b[1] = b_y;
  assign in_tri.b[2] = b_z;
  assign in_tri.c[0] = c_x;
  assign in_tri.c[1] = c_y;
  assign in_tri.c[2] = c_z;

  assign out_a_x = out_tri.a[0];
  assign out_a_y = out_tri.a[1];
  assign out_a_z = out_tri.a[2];
  assign out_b_x = out_tri.b[0];
  assign out_b_y = out_tri.b[1];
  assign out_b_z = out_tri.b[2];
  assign out_c_x = out_tri.c[0];
  assign out_c_y = out_tri.c[1];
  assign out_c_z = out_tri.c[2];

  stsd_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .depth_we    (depth_we),
    .depth_wdata (depth_wdata),
    .push        (push),
    .full        (full),
    .in_tri      (in_tri),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item)
  );

  stsd_mid u_mid (
    .clk (clk),
    .rst (rst),
    .req (mid_req),
    .rsp (mid_rsp)
  );

  stsd_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .mid_req (mid_req),
    .mid_rsp (mid_rsp),
    .empty   (empty),
    .pop     (pop),
    .out_tri (out_tri),
    .last    (last)
  );

endmodule

FILE: hdl/stsd_front.sv
// Front end: depth register, depth clamp and a short triangle queue.
module stsd_front #(
  parameter int MAX_DEPTH = stsd_pkg::MAX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         depth_we,
  input  logic [stsd_pkg::DEPTH_W-1:0] depth_wdata,
  input  logic                         push,
  output logic                         full,
  input  stsd_pkg::tri_t               in_tri,
  output logic                         q_valid,
  input  logic                         q_pop,
  output stsd_pkg::item_t              q_item
);
  import stsd_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_used;
  item_t              slots [QDEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        count;
  logic               do_push;
  logic               do_pop;

  assign depth_used = (depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth;
  assign full       = (count == (PW+1)'(QDEPTH));
  assign q_valid    = (count != '0);
  assign q_item     = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= DEPTH_W'(3);
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (depth_we) begin
        depth <= depth_wdata;
      end
      if (do_push) begin
        slots[wr_ptr] <= '{face: in_tri, depth: depth_used};
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

FILE: hdl/stsd_mid.sv
// Midpoint unit: edge sum, squared length, serial divide and serial square root.
module stsd_mid (
  input  logic               clk,
  input  logic               rst,
  input  stsd_pkg::mid_req_t req,
  output stsd_pkg::mid_rsp_t rsp
);
  import stsd_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_SQ, M_LEN, M_DIV, M_SQRT, M_DONE} state_t;

  state_t                 state;
  logic signed [SW-1:0]   s     [3];
  logic [SQW-1:0]         sq    [3];
  logic [LW-1:0]          len;
  logic [LW-1:0]          rem   [3];
  logic [2*RW-1:0]        quo   [3];
  logic [RW-1:0]          root  [3];
  logic [RMW-1:0]         srem  [3];
  logic [STEP_W-1:0]      step;
  logic                   done;
  vec_t                   m;

  logic signed [2*SW-1:0] prod  [3];
  logic [LW:0]            dsh   [3];
  logic                   dbit  [3];
  logic [RMW+1:0]         r2    [3];
  logic [RMW+1:0]         trial [3];
  logic                   sbit  [3];
  coord_t                 mag   [3];
  coord_t                 neg   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]  = s[i] * s[i];
      dsh[i]   = (step == '0) ? {1'b0, rem[i]} : {rem[i], 1'b0};
      dbit[i]  = (dsh[i] >= {1'b0, len});
      r2[i]    = {srem[i], quo[i][2*RW-1 -: 2]};
      trial[i] = (RMW+2)'({root[i], 2'b01});
      sbit[i]  = (r2[i] >= trial[i]);
      mag[i]   = CW'(root[i]);
      neg[i]   = coord_t'('0) - mag[i];
    end
  end

  assign rsp.done = done;
  assign rsp.m    = m;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            for (int i = 0; i < 3; i++) begin
              s[i] <= $signed({req.p[i][CW-1], req.p[i]})
                    + $signed({req.q[i][CW-1], req.q[i]});
            end
            state <= M_SQ;
          end
        end
        M_SQ: begin
          for (int i = 0; i < 3; i++) begin
            sq[i] <= prod[i][SQW-1:0];
          end
          state <= M_LEN;
        end
        M_LEN: begin
          len <= LW'(sq[0]) + LW'(sq[1]) + LW'(sq[2]);
          for (int i = 0; i < 3; i++) begin
            rem[i] <= LW'(sq[i]);
            quo[i] <= '0;
          end
          step  <= '0;
          state <= M_DIV;
        end
        M_DIV: begin
          if (len == '0) begin
            // zero-length edge sum: result is the origin
            for (int i = 0; i < 3; i++) begin
              root[i] <= '0;
            end
            state <= M_DONE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (dbit[i]) begin
                rem[i] <= LW'(dsh[i] - {1'b0, len});
              end else begin
                rem[i] <= dsh[i][LW-1:0];
              end
              quo[i] <= {quo[i][2*RW-2:0], dbit[i]};
            end
            if (step == STEP_W'(QW - 1)) begin
              step <= '0;
              for (int i = 0; i < 3; i++) begin
                root[i] <= '0;
                srem[i] <= '0;
              end
              state <= M_SQRT;
            end else begin
              step <= step + STEP_W'(1);
            end
          end
        end
        M_SQRT: begin
          // one root bit per cycle, two radicand bits shifted out
          for (int i = 0; i < 3; i++) begin
            if (sbit[i]) begin
              srem[i] <= RMW'(r2[i] - trial[i]);
              root[i] <= {root[i][RW-2:0], 1'b1};
            end else begin
              srem[i] <= r2[i][RMW-1:0];
              root[i] <= {root[i][RW-2:0], 1'b0};
            end
            quo[i] <= {quo[i][2*RW-3:0], 2'b00};
          end
          if (step == STEP_W'(RW - 1)) begin
            step  <= '0;
            state <= M_DONE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        M_DONE: begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= s[i][SW-1] ? neg[i] : mag[i];
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/stsd_back.sv
// Back end: depth-first subdivision sequencer with level stack and result register.
module stsd_back #(
  parameter int MAX_DEPTH = stsd_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  stsd_pkg::item_t    q_item,
  output stsd_pkg::mid_req_t mid_req,
  input  stsd_pkg::mid_rsp_t mid_rsp,
  output logic               empty,
  input  logic               pop,
  output stsd_pkg::tri_t     out_tri,
  output logic               last
);
  import stsd_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W = 2 * MAX_DEPTH;

  localparam logic [1:0] MID_AB    = 2'd0;
  localparam logic [1:0] MID_AC    = 2'd1;
  localparam logic [1:0] MID_BC    = 2'd2;
  localparam logic [1:0] CHILD_A   = 2'd0;
  localparam logic [1:0] CHILD_B   = 2'd1;
  localparam logic [1:0] CHILD_C   = 2'd2;
  localparam logic [1:0] CHILD_CTR = 2'd3;

  typedef enum logic [2:0] {B_IDLE, B_MID_GO, B_MID_WAIT, B_CHILD, B_EMIT} state_t;

  state_t             state;
  tri_t               tri_st [MAX_DEPTH+1];
  vec_t [2:0]         mid_st [MAX_DEPTH];
  logic [LVL_W-1:0]   lvl;
  logic [LVL_W-1:0]   d;
  logic [LVL_W-1:0]   up_lvl;
  logic [LVL_W-1:0]   sh;
  logic [1:0]         mj;
  logic [1:0]         dig;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_sh;
  logic [CNT_W-1:0]   last_cnt;
  logic               is_last;
  logic               emit_fire;
  logic               found;
  logic               out_valid;
  tri_t               cur;
  tri_t               child;
  vec_t [2:0]         cur_mid;
  tri_t               out_reg;
  logic               out_last;

  assign cur       = tri_st[lvl];
  assign cur_mid   = mid_st[lvl];
  assign sh        = d - lvl - LVL_W'(1);
  assign cnt_sh    = cnt >> {sh, 1'b0};
  assign dig       = cnt_sh[1:0];
  assign last_cnt  = ~({CNT_W{1'b1}} << {d, 1'b0});
  assign is_last   = (cnt == last_cnt);
  assign emit_fire = (state == B_EMIT) && (!out_valid || pop);
  assign q_pop     = (state == B_IDLE) && q_valid;
  assign empty     = !out_valid;
  assign out_tri   = out_reg;
  assign last      = out_last;

  // shallowest level whose child digit changes on the next leaf
  always_comb begin
    found  = 1'b0;
    up_lvl = '0;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (!found && (LVL_W'(j) < d) && (cnt[2*j +: 2] != CHILD_CTR)) begin
        found  = 1'b1;
        up_lvl = d - LVL_W'(j) - LVL_W'(1);
      end
    end
  end

  always_comb begin
    case (dig)
      CHILD_A:   child = '{a: cur.a, b: cur_mid[MID_AB], c: cur_mid[MID_AC]};
      CHILD_B:   child = '{a: cur_mid[MID_AB], b: cur.b, c: cur_mid[MID_BC]};
      CHILD_C:   child = '{a: cur_mid[MID_AC], b: cur_mid[MID_BC], c: cur.c};
      default:   child = '{a: cur_mid[MID_AB], b: cur_mid[MID_BC], c: cur_mid[MID_AC]};
    endcase
  end

  always_comb begin
    mid_req.start = (state == B_MID_GO);
    case (mj)
      MID_AB: begin
        mid_req.p = cur.a;
        mid_req.q = cur.b;
      end
      MID_AC: begin
        mid_req.p = cur.a;
        mid_req.q = cur.c;
      end
      default: begin
        mid_req.p = cur.b;
        mid_req.q = cur.c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      lvl       <= '0;
      d         <= '0;
      cnt       <= '0;
      mj        <= MID_AB;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            tri_st[0] <= q_item.face;
            d         <= LVL_W'(q_item.depth);
            cnt       <= '0;
            lvl       <= '0;
            mj        <= MID_AB;
            state     <= (q_item.depth == '0) ? B_EMIT : B_MID_GO;
          end
        end
        B_MID_GO: state <= B_MID_WAIT;
        B_MID_WAIT: begin
          if (mid_rsp.done) begin
            mid_st[lvl][mj] <= mid_rsp.m;
            if (mj == MID_BC) begin
              state <= B_CHILD;
            end else begin
              mj    <= mj + 2'd1;
              state <= B_MID_GO;
            end
          end
        end
        B_CHILD: begin
          tri_st[lvl + LVL_W'(1)] <= child;
          lvl   <= lvl + LVL_W'(1);
          mj    <= MID_AB;
          state <= ((lvl + LVL_W'(1)) == d) ? B_EMIT : B_MID_GO;
        end
        B_EMIT: begin
          if (emit_fire) begin
            out_reg   <= cur;
            out_last  <= is_last;
            if (is_last) begin
              state <= B_IDLE;
            end else begin
              // climb back to the level whose digit advances
              cnt   <= cnt + CNT_W'(1);
              lvl   <= up_lvl;
              state <= B_CHILD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mid_rsp.done |-> state == B_MID_WAIT)
    else $error("midpoint result arrived outside wait state");
  a_lvl_in_range: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> lvl <= d)
    else $error("level beyond subdivision depth");
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && is_last) |=> state == B_IDLE)
    else $error("final leaf did not end the triangle");
`endif

endmodule
